@@ rtl/rvpm_pkg.sv @@
// ----------------------------------------------------------------------------
// rvpm_pkg
// shared types, widths and constants of the rotation vector to pose block
// ----------------------------------------------------------------------------
package rvpm_pkg;

  localparam int unsigned ATAN_LEN = 24;

  // vectoring datapath, magnitude and angle widths
  localparam int unsigned XW = 36;
  localparam int unsigned THW = 33;
  localparam int unsigned REMW = THW + 1;
  localparam int unsigned QW = 33;
  localparam int unsigned DIV_STEPS = QW;
  localparam int unsigned KW = 34;
  localparam int unsigned CW = 33;
  localparam int unsigned AW = 36;

  // cordic gain correction in Q30
  localparam logic [29:0] INVK = 30'd652032874;

  localparam logic signed [CW-1:0] Q30_ONE = 33'sd1073741824;
  localparam logic signed [AW-1:0] Q30_PI = 36'sd3373259426;
  localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [AW-1:0] Q30_TWO_PI = 36'sd6746518852;
  localparam logic signed [AW-1:0] Q30_FOUR_PI = 36'sd13493037704;

  // arctangent of 2^-i in Q30
  localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127
  };

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } rvpm_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [15:0] col0;
    logic signed [15:0] col1;
    logic signed [15:0] col2;
    logic signed [31:0] trans_out;
    logic               last_row;
  } rvpm_out_t;

endpackage

@@ rtl/rotation_vector_to_pose_matrix.sv @@
// ----------------------------------------------------------------------------
// rotation_vector_to_pose_matrix
// rotation vector plus translation to the top three rows of a pose matrix
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high so
// that words enter no faster than the single result channel, which carries
// three rows per word, can send them out. Each word yields rows 0, 1 and 2 on
// consecutive cycles, each marked by result_valid_o for one cycle; the receiver
// cannot stall and must take them. The datapath is a fixed chain of cells that
// advances every cycle: two cordic vectoring chains with gain correction
// (theta), then side by side a cordic rotation chain (sin, cos) and three
// 33-step restoring divider chains (unit axis), then a four-stage rodrigues
// matrix assembly. A zero rotation vector gives the identity rotation. The
// translation passes through unchanged.
// ----------------------------------------------------------------------------
module rotation_vector_to_pose_matrix
  import rvpm_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  rvpm_in_t  item_i,
  output logic      result_valid_o,
  output rvpm_out_t result_o
);

  localparam int unsigned NS = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  // theta lies this many registers behind the input register
  localparam int unsigned LT = 2 * NS + 4;
  localparam int unsigned CS_DELAY = DIV_STEPS - 4 - NS;
  localparam int unsigned OUT_DELAY = LT + DIV_STEPS + 4;

  // ---------------- input word and pacing ----------------
  logic [1:0]  gap_q;
  logic        accept;
  logic        vin_q;
  logic [15:0] mag_d [3];
  logic [15:0] mag_q [3];
  logic [2:0]  sgn_q;
  logic [95:0] trans_q;

  assign accept = start && !busy;
  assign busy   = (gap_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 2'd0;
      vin_q <= 1'b0;
    end else begin
      vin_q <= accept;
      if (accept) gap_q <= 2'd2;
      else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
    end
  end

  // magnitudes of the vector components, -32768 maps to 0x8000
  always_comb begin
    mag_d[0] = item_i.rot_x[15] ? 16'(-item_i.rot_x) : item_i.rot_x;
    mag_d[1] = item_i.rot_y[15] ? 16'(-item_i.rot_y) : item_i.rot_y;
    mag_d[2] = item_i.rot_z[15] ? 16'(-item_i.rot_z) : item_i.rot_z;
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    sgn_q   <= {item_i.rot_z[15], item_i.rot_y[15], item_i.rot_x[15]};
    trans_q <= {item_i.trans_x, item_i.trans_y, item_i.trans_z};
  end

  // ---------------- theta: |(x, y)| then |(that, z)| ----------------
  logic signed [XW-1:0] p1x [NS+1];
  logic signed [XW-1:0] p1y [NS+1];
  logic signed [XW-1:0] p2x [NS+1];
  logic signed [XW-1:0] p2y [NS+1];
  logic signed [XW-1:0] theta_w;
  logic [15:0]          z_dly;
  logic [THW-1:0]       theta;

  // components enter in Q.28
  assign p1x[0] = signed'({4'b0, mag_q[0], 16'b0});
  assign p1y[0] = signed'({4'b0, mag_q[1], 16'b0});

  for (genvar i = 0; i < NS; i++) begin : g_pass1
    rvpm_vec_cell #(.SHIFT(i)) u_cell (
      .clk_i, .x_i(p1x[i]), .y_i(p1y[i]), .x_o(p1x[i+1]), .y_o(p1y[i+1])
    );
  end

  rvpm_gain u_gain1 (.clk_i, .x_i(p1x[NS]), .mag_o(p2x[0]));

  // z waits out the first pass and its gain correction
  rvpm_delay #(.WIDTH(16), .DEPTH(NS + 2)) u_z_dly (
    .clk_i, .rst_ni, .d_i(mag_q[2]), .q_o(z_dly)
  );
  assign p2y[0] = signed'({4'b0, z_dly, 16'b0});

  for (genvar i = 0; i < NS; i++) begin : g_pass2
    rvpm_vec_cell #(.SHIFT(i)) u_cell (
      .clk_i, .x_i(p2x[i]), .y_i(p2y[i]), .x_o(p2x[i+1]), .y_o(p2y[i+1])
    );
  end

  rvpm_gain u_gain2 (.clk_i, .x_i(p2x[NS]), .mag_o(theta_w));
  assign theta = theta_w[THW-1:0];

  // ---------------- angle reduction to [-pi/2, pi/2] ----------------
  logic signed [AW-1:0] a0, a1_q, a2_q, a3_q;
  logic                 neg3_q;

  // angle in Q30 is theta * 4
  assign a0 = signed'({1'b0, theta, 2'b00});

  always_ff @(posedge clk_i) begin
    // modulo two pi, the angle stays below three turns
    if (a0 >= Q30_FOUR_PI) a1_q <= a0 - Q30_FOUR_PI;
    else if (a0 >= Q30_TWO_PI) a1_q <= a0 - Q30_TWO_PI;
    else a1_q <= a0;
    // fold into (-pi, pi]
    a2_q <= (a1_q > Q30_PI) ? a1_q - Q30_TWO_PI : a1_q;
    // outer half turns rotate by pi and flip sin and cos at the end
    if (a2_q > Q30_HALF_PI) begin
      a3_q   <= a2_q - Q30_PI;
      neg3_q <= 1'b1;
    end else if (a2_q < -Q30_HALF_PI) begin
      a3_q   <= a2_q + Q30_PI;
      neg3_q <= 1'b1;
    end else begin
      a3_q   <= a2_q;
      neg3_q <= 1'b0;
    end
  end

  // ---------------- sin and cos chain ----------------
  logic signed [CW-1:0] rx [NS+1];
  logic signed [CW-1:0] ry [NS+1];
  logic signed [AW-1:0] ra [NS+1];
  logic                 neg_dly;
  logic signed [CW-1:0] cos_q, sin_q;
  logic [2*CW-1:0]      cs_dly;

  // starting from (1/K, 0) leaves no gain to remove afterwards
  assign rx[0] = signed'({{(CW-30){1'b0}}, INVK});
  assign ry[0] = '0;
  assign ra[0] = a3_q;

  for (genvar i = 0; i < NS; i++) begin : g_rot
    rvpm_rot_cell #(.SHIFT(i)) u_cell (
      .clk_i, .x_i(rx[i]), .y_i(ry[i]), .a_i(ra[i]),
      .x_o(rx[i+1]), .y_o(ry[i+1]), .a_o(ra[i+1])
    );
  end

  rvpm_delay #(.WIDTH(1), .DEPTH(NS)) u_neg_dly (
    .clk_i, .rst_ni, .d_i(neg3_q), .q_o(neg_dly)
  );

  always_ff @(posedge clk_i) begin
    cos_q <= neg_dly ? -rx[NS] : rx[NS];
    sin_q <= neg_dly ? -ry[NS] : ry[NS];
  end

  // line up with the end of the divider chains
  rvpm_delay #(.WIDTH(2 * CW), .DEPTH(CS_DELAY)) u_cs_dly (
    .clk_i, .rst_ni, .d_i({cos_q, sin_q}), .q_o(cs_dly)
  );

  // ---------------- unit axis: |v_i| * 2^30 / theta ----------------
  logic [47:0]     amag_dly;
  logic [15:0]     amag [3];
  logic [2:0]      ksgn_dly;
  logic [REMW-1:0] dr [3][DIV_STEPS+1];
  logic [THW-1:0]  dd [3][DIV_STEPS+1];
  logic [QW-1:0]   dq [3][DIV_STEPS+1];
  logic [QW-1:0]   kq [3];

  rvpm_delay #(.WIDTH(48), .DEPTH(LT)) u_amag_dly (
    .clk_i, .rst_ni, .d_i({mag_q[2], mag_q[1], mag_q[0]}), .q_o(amag_dly)
  );
  rvpm_delay #(.WIDTH(3), .DEPTH(LT + DIV_STEPS)) u_sgn_dly (
    .clk_i, .rst_ni, .d_i(sgn_q), .q_o(ksgn_dly)
  );

  assign amag[0] = amag_dly[15:0];
  assign amag[1] = amag_dly[31:16];
  assign amag[2] = amag_dly[47:32];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    // dividend is |v| * 2^46 and only its top bits are nonzero
    assign dr[l][0] = {5'b0, amag[l], 13'b0};
    assign dd[l][0] = theta;
    assign dq[l][0] = '0;
    for (genvar b = 0; b < DIV_STEPS; b++) begin : g_step
      rvpm_div_cell u_cell (
        .clk_i,
        .r_i(dr[l][b]), .d_i(dd[l][b]), .q_i(dq[l][b]),
        .r_o(dr[l][b+1]), .d_o(dd[l][b+1]), .q_o(dq[l][b+1])
      );
    end
    assign kq[l] = dq[l][DIV_STEPS];
  end

  // ---------------- rodrigues assembly ----------------
  logic signed [15:0] ent [9];

  rvpm_matrix u_matrix (
    .clk_i,
    .q_i(kq),
    .neg_i(ksgn_dly),
    .zero_i(dd[0][DIV_STEPS] == '0),
    .c_i(signed'(cs_dly[2*CW-1:CW])),
    .s_i(signed'(cs_dly[CW-1:0])),
    .ent_o(ent)
  );

  // ---------------- row sequencer ----------------
  logic        vout;
  logic [95:0] trans_dly;
  rvpm_out_t   rows_q [3];
  logic [1:0]  row_q;
  logic        act_q;

  rvpm_delay #(.WIDTH(1), .DEPTH(OUT_DELAY)) u_vld_dly (
    .clk_i, .rst_ni, .d_i(vin_q), .q_o(vout)
  );
  rvpm_delay #(.WIDTH(96), .DEPTH(OUT_DELAY)) u_trans_dly (
    .clk_i, .rst_ni, .d_i(trans_q), .q_o(trans_dly)
  );

  // words arrive no closer than busy lets them enter, so a new one only lands as the
  // last row of the previous one goes out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      row_q <= 2'd0;
    end else if (vout) begin
      act_q <= 1'b1;
      row_q <= 2'd0;
    end else if (act_q) begin
      act_q <= (row_q != 2'd2);
      row_q <= row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vout) begin
      for (int r = 0; r < 3; r++) begin
        rows_q[r].row_index <= 2'(r);
        rows_q[r].col0      <= ent[3*r];
        rows_q[r].col1      <= ent[3*r+1];
        rows_q[r].col2      <= ent[3*r+2];
        rows_q[r].last_row  <= (r == 2);
      end
      rows_q[0].trans_out <= trans_dly[95:64];
      rows_q[1].trans_out <= trans_dly[63:32];
      rows_q[2].trans_out <= trans_dly[31:0];
    end
  end

  always_comb begin
    case (row_q)
      2'd0:    result_o = rows_q[0];
      2'd1:    result_o = rows_q[1];
      default: result_o = rows_q[2];
    endcase
  end

  assign result_valid_o = act_q;

endmodule

@@ rtl/rvpm_delay.sv @@
// ----------------------------------------------------------------------------
// rvpm_delay
// fixed-length shift line that keeps side data aligned with the cell chains
// ----------------------------------------------------------------------------
module rvpm_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
    end else begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

@@ rtl/rvpm_vec_cell.sv @@
// ----------------------------------------------------------------------------
// rvpm_vec_cell
// one cordic vectoring step, drives y toward zero
// ----------------------------------------------------------------------------
module rvpm_vec_cell
  import rvpm_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o
);

  logic signed [XW-1:0] x_d, y_d, x_q, y_q;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_d = x_i + (y_i >>> SHIFT);
      y_d = y_i - (x_i >>> SHIFT);
    end else begin
      x_d = x_i - (y_i >>> SHIFT);
      y_d = y_i + (x_i >>> SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

@@ rtl/rvpm_gain.sv @@
// ----------------------------------------------------------------------------
// rvpm_gain
// two-stage cordic gain correction, x * INVK >> 30 for nonnegative x
// ----------------------------------------------------------------------------
module rvpm_gain
  import rvpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic signed [XW-1:0] x_i,
  output logic signed [XW-1:0] mag_o
);

  localparam int unsigned LOW_W = 17;
  localparam int unsigned HIGH_W = XW - 1 - LOW_W;

  logic [HIGH_W+29:0] hi_q;
  logic [LOW_W+29:0]  lo_q;
  logic [HIGH_W+LOW_W+30:0] sum;
  logic signed [XW-1:0] mag_q;

  // x never goes negative, so the sign bit is dropped
  always_ff @(posedge clk_i) begin
    hi_q <= x_i[XW-2:LOW_W] * INVK;
    lo_q <= x_i[LOW_W-1:0] * INVK;
  end

  assign sum = {1'b0, hi_q, {LOW_W{1'b0}}} + {{(HIGH_W+1){1'b0}}, lo_q};

  always_ff @(posedge clk_i) begin
    mag_q <= signed'({1'b0, sum[HIGH_W+LOW_W+29:30]});
  end

  assign mag_o = mag_q;

endmodule

@@ rtl/rvpm_rot_cell.sv @@
// ----------------------------------------------------------------------------
// rvpm_rot_cell
// one cordic rotation step, drives the residual angle toward zero
// ----------------------------------------------------------------------------
module rvpm_rot_cell
  import rvpm_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [AW-1:0] a_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [AW-1:0] a_o
);

  localparam logic signed [AW-1:0] STEP_ANGLE =
    signed'({{(AW-30){1'b0}}, ATAN_Q30[SHIFT]});

  logic signed [CW-1:0] x_d, y_d, x_q, y_q;
  logic signed [AW-1:0] a_d, a_q;

  always_comb begin
    if (!a_i[AW-1]) begin
      x_d = x_i - (y_i >>> SHIFT);
      y_d = y_i + (x_i >>> SHIFT);
      a_d = a_i - STEP_ANGLE;
    end else begin
      x_d = x_i + (y_i >>> SHIFT);
      y_d = y_i - (x_i >>> SHIFT);
      a_d = a_i + STEP_ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    a_q <= a_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign a_o = a_q;

endmodule

@@ rtl/rvpm_div_cell.sv @@
// ----------------------------------------------------------------------------
// rvpm_div_cell
// one restoring division step, one quotient bit
// ----------------------------------------------------------------------------
module rvpm_div_cell
  import rvpm_pkg::*;
(
  input  logic            clk_i,
  input  logic [REMW-1:0] r_i,
  input  logic [THW-1:0]  d_i,
  input  logic [QW-1:0]   q_i,
  output logic [REMW-1:0] r_o,
  output logic [THW-1:0]  d_o,
  output logic [QW-1:0]   q_o
);

  logic [REMW-1:0] trial, r_d, r_q;
  logic [QW-1:0]   q_d, q_q;
  logic [THW-1:0]  d_q;

  assign trial = {r_i[REMW-2:0], 1'b0};

  always_comb begin
    if (trial >= {1'b0, d_i}) begin
      r_d = trial - {1'b0, d_i};
      q_d = {q_i[QW-2:0], 1'b1};
    end else begin
      r_d = trial;
      q_d = {q_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    d_q <= d_i;
  end

  assign r_o = r_q;
  assign q_o = q_q;
  assign d_o = d_q;

endmodule

@@ rtl/rvpm_matrix.sv @@
// ----------------------------------------------------------------------------
// rvpm_matrix
// rodrigues assembly of the 3x3 rotation from axis, cos and sin, to Q2.14
// ----------------------------------------------------------------------------
module rvpm_matrix
  import rvpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic [QW-1:0]        q_i [3],
  input  logic [2:0]           neg_i,
  input  logic                 zero_i,
  input  logic signed [CW-1:0] c_i,
  input  logic signed [CW-1:0] s_i,
  output logic signed [15:0]   ent_o [9]
);

  localparam int unsigned KKW = 36;
  localparam int unsigned SKW = 35;
  localparam int unsigned OMW = 34;
  localparam int unsigned PW = 36;
  localparam int unsigned MW = 38;

  // symmetric products k_i * k_j
  localparam int unsigned P00 = 0;
  localparam int unsigned P01 = 1;
  localparam int unsigned P02 = 2;
  localparam int unsigned P11 = 3;
  localparam int unsigned P12 = 4;
  localparam int unsigned P22 = 5;
  localparam int unsigned PA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned PB [6] = '{0, 1, 2, 1, 2, 2};

  function automatic logic signed [15:0] to_q14(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] r;
    r = (v + MW'(32768)) >>> 16;
    if (r > MW'(32767)) return 16'sh7fff;
    else if (r < -MW'(32768)) return 16'sh8000;
    else return r[15:0];
  endfunction

  logic signed [KW-1:0]  k_q [3];
  logic signed [CW-1:0]  c0_q, s0_q, c1_q, c2_q;
  logic signed [KKW-1:0] kk_q [6];
  logic signed [SKW-1:0] sk1_q [3], sk2_q [3];
  logic signed [OMW-1:0] omc_q;
  logic signed [PW-1:0]  p_q [6];
  logic signed [15:0]    ent_q [9];

  logic signed [2*KW-1:0]      kk_full [6];
  logic signed [CW+KW-1:0]     sk_full [3];
  logic signed [OMW+KKW-1:0]   p_full [6];
  logic signed [MW-1:0]        m [9];

  // axis sign, zero rotation falls back to identity
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (zero_i) k_q[i] <= '0;
      else if (neg_i[i]) k_q[i] <= -signed'({1'b0, q_i[i]});
      else k_q[i] <= signed'({1'b0, q_i[i]});
    end
    c0_q <= zero_i ? Q30_ONE : c_i;
    s0_q <= zero_i ? '0 : s_i;
  end

  always_comb begin
    for (int p = 0; p < 6; p++) kk_full[p] = k_q[PA[p]] * k_q[PB[p]];
    for (int i = 0; i < 3; i++) sk_full[i] = s0_q * k_q[i];
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) kk_q[p] <= kk_full[p][30+KKW-1:30];
    for (int i = 0; i < 3; i++) sk1_q[i] <= sk_full[i][30+SKW-1:30];
    omc_q <= OMW'(Q30_ONE) - OMW'(c0_q);
    c1_q  <= c0_q;
  end

  always_comb begin
    for (int p = 0; p < 6; p++) p_full[p] = omc_q * kk_q[p];
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) p_q[p] <= p_full[p][30+PW-1:30];
    sk2_q <= sk1_q;
    c2_q  <= c1_q;
  end

  always_comb begin
    m[0] = MW'(p_q[P00]) + MW'(c2_q);
    m[1] = MW'(p_q[P01]) - MW'(sk2_q[2]);
    m[2] = MW'(p_q[P02]) + MW'(sk2_q[1]);
    m[3] = MW'(p_q[P01]) + MW'(sk2_q[2]);
    m[4] = MW'(p_q[P11]) + MW'(c2_q);
    m[5] = MW'(p_q[P12]) - MW'(sk2_q[0]);
    m[6] = MW'(p_q[P02]) - MW'(sk2_q[1]);
    m[7] = MW'(p_q[P12]) + MW'(sk2_q[0]);
    m[8] = MW'(p_q[P22]) + MW'(c2_q);
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 9; e++) ent_q[e] <= to_q14(m[e]);
  end

  assign ent_o = ent_q;

endmodule
